// ===== hdl/bti_pkg.sv =====
// shared types and constants of the breakpoint table interpolator
`default_nettype none

package bti_pkg;

	localparam int S_DATA_W = 64;
	localparam int M_DATA_W = 24;
	localparam int IDX_W    = 4;
	localparam int KEY_W    = 16;
	localparam int ANG_W    = 16;
	localparam int RATE_W   = 24;
	localparam int OUT_W    = 17;
	localparam int ENTRY_W  = 5;
	localparam int V_W      = 12;
	localparam int RMAG_W   = 17;

	localparam int IDX_LSB  = 0;
	localparam int KEY_LSB  = IDX_LSB + IDX_W;
	localparam int ANG_LSB  = KEY_LSB + KEY_W;
	localparam int RATE_LSB = ANG_LSB + ANG_W;

	localparam logic [ENTRY_W-1:0] ENTRIES_RESET = 5'd2;
	localparam logic [ENTRY_W-1:0] ENTRIES_MIN   = 5'd2;

	// +-6000 ft/min in 1/16 units
	localparam logic signed [RATE_W-1:0] RATE_LIMIT = 24'sd96000;
	// ceil(2^23 / 60), exact for magnitudes up to the rate limit
	localparam logic [17:0] RECIP_60    = 18'd139811;
	localparam int          RECIP_SHIFT = 23;
	localparam int          VMAG_W      = 11;

	localparam int               DIV_CNT_W = 3;
	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'd7;

	localparam logic MODE_WRITE   = 1'b0;
	localparam logic MODE_CONVERT = 1'b1;

	typedef struct packed {
		logic capture;
		logic write_entry;
		logic check;
		logic scale;
		logic search_go;
		logic prep;
		logic mul;
		logic div_load;
		logic div_step;
		logic load_out;
	} bti_cmd_t;

	typedef struct packed {
		logic mode;
		logic rate_same;
		logic search_done;
		logic search_sat;
		logic div_last;
		logic out_free;
	} bti_sts_t;

endpackage

`default_nettype wire

// ===== hdl/bti_ctrl.sv =====
// sequencing state machine of the breakpoint table interpolator
`default_nettype none

module bti_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  bti_pkg::bti_sts_t sts,
	output bti_pkg::bti_cmd_t cmd
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DEC,
		ST_SCALE,
		ST_SEARCH,
		ST_PREP,
		ST_MUL,
		ST_DLOAD,
		ST_DIV,
		ST_OUT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (sts.mode == bti_pkg::MODE_WRITE || sts.rate_same) state_q <= ST_IDLE;
					else state_q <= ST_SCALE;
				end
				ST_SCALE: state_q <= ST_SEARCH;
				ST_SEARCH: begin
					if (sts.search_done) state_q <= sts.search_sat ? ST_OUT : ST_PREP;
				end
				ST_PREP:  state_q <= ST_MUL;
				ST_MUL:   state_q <= ST_DLOAD;
				ST_DLOAD: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_last) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (sts.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		in_ready         = (state_q == ST_IDLE);
		cmd              = '0;
		cmd.capture      = in_ready && in_valid;
		cmd.write_entry  = (state_q == ST_DEC) && (sts.mode == bti_pkg::MODE_WRITE);
		cmd.check        = (state_q == ST_DEC) && (sts.mode == bti_pkg::MODE_CONVERT)
			&& !sts.rate_same;
		cmd.scale        = (state_q == ST_SCALE);
		cmd.search_go    = (state_q == ST_SCALE);
		cmd.prep         = (state_q == ST_PREP);
		cmd.mul          = (state_q == ST_MUL);
		cmd.div_load     = (state_q == ST_DLOAD);
		cmd.div_step     = (state_q == ST_DIV);
		cmd.load_out     = (state_q == ST_OUT) && sts.out_free;
	end

endmodule

`default_nettype wire

// ===== hdl/bti_dpath.sv =====
// datapath: breakpoint memories, rate scaling, search, multiply and radix-4 divide
`default_nettype none

module bti_dpath #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  bti_pkg::bti_cmd_t                    cmd,
	output bti_pkg::bti_sts_t                    sts,
	input  wire  [bti_pkg::S_DATA_W-1:0]         s_tdata,
	input  wire                                  s_tuser,
	input  wire                                  cfg_wen,
	input  wire  [bti_pkg::ENTRY_W-1:0]          cfg_wdata,
	output logic                                 m_tvalid,
	input  wire                                  m_tready,
	output logic [bti_pkg::OUT_W-1:0]            res_data
);

	localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
	localparam int CW = $clog2(MAX_ENTRIES + 1);

	// captured item
	logic                               mode_q;
	logic [bti_pkg::IDX_W-1:0]          idx_q;
	logic signed [bti_pkg::KEY_W-1:0]   key_q;
	logic signed [bti_pkg::ANG_W-1:0]   ang_q;
	logic signed [bti_pkg::RATE_W-1:0]  rate_q;

	logic [bti_pkg::ENTRY_W-1:0]        entries_q;
	logic signed [bti_pkg::RATE_W-1:0]  last_rate_q;
	logic [CW-1:0]                      n_use;

	logic signed [bti_pkg::KEY_W-1:0]   key_mem [MAX_ENTRIES];
	logic signed [bti_pkg::ANG_W-1:0]   ang_mem [MAX_ENTRIES];

	logic [bti_pkg::RMAG_W-1:0]         rmag_q;
	logic                               rneg_q;
	logic signed [bti_pkg::V_W-1:0]     v_q;

	logic signed [bti_pkg::RATE_W-1:0]  rate_cl;
	logic signed [bti_pkg::RATE_W-1:0]  rate_abs;
	logic [34:0]                        scale_prod;
	logic [bti_pkg::VMAG_W-1:0]         vmag;

	logic [CW-1:0]                      cnt_q;
	logic                               searching_q;
	logic                               vld_s1;
	logic [CW-1:0]                      tag_s1;
	logic signed [bti_pkg::KEY_W-1:0]   key_rd_s1;
	logic signed [bti_pkg::ANG_W-1:0]   ang_rd_s1;
	logic                               lt;
	logic                               done_now;
	logic                               sat_now;

	logic signed [bti_pkg::KEY_W-1:0]   k0_q;
	logic signed [bti_pkg::KEY_W-1:0]   k1_q;
	logic signed [bti_pkg::ANG_W-1:0]   a0_q;
	logic signed [bti_pkg::ANG_W-1:0]   a1_q;
	logic                               sat_q;

	logic signed [16:0]                 dv;
	logic signed [16:0]                 da;
	logic signed [16:0]                 dk;
	logic [15:0]                        dv_q;
	logic [15:0]                        da_mag_q;
	logic                               da_neg_q;
	logic [15:0]                        dk_q;
	logic [31:0]                        prod_q;

	logic [16:0]                        rem_q;
	logic [15:0]                        dl_q;
	logic [15:0]                        quo_q;
	logic [bti_pkg::DIV_CNT_W-1:0]      dcnt_q;
	logic [16:0]                        r1;
	logic [16:0]                        r1b;
	logic [16:0]                        r2;
	logic [16:0]                        r2b;
	logic                               qb1;
	logic                               qb2;

	logic signed [17:0]                 sq;
	logic signed [17:0]                 base;
	logic signed [17:0]                 neg_res;
	logic                               m_tvalid_q;
	logic [bti_pkg::OUT_W-1:0]          res_q;

	// entry count saturated to the table
	always_comb begin
		if (entries_q < bti_pkg::ENTRIES_MIN) n_use = CW'(bti_pkg::ENTRIES_MIN);
		else if (32'(entries_q) > MAX_ENTRIES) n_use = CW'(MAX_ENTRIES);
		else n_use = CW'(entries_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= bti_pkg::ENTRIES_RESET;
		end else if (cfg_wen) begin
			entries_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			mode_q <= s_tuser;
			idx_q  <= s_tdata[bti_pkg::IDX_LSB +: bti_pkg::IDX_W];
			key_q  <= $signed(s_tdata[bti_pkg::KEY_LSB +: bti_pkg::KEY_W]);
			ang_q  <= $signed(s_tdata[bti_pkg::ANG_LSB +: bti_pkg::ANG_W]);
			rate_q <= $signed(s_tdata[bti_pkg::RATE_LSB +: bti_pkg::RATE_W]);
		end
	end

	// breakpoint memories
	always_ff @(posedge clk) begin
		if (cmd.write_entry && (32'(idx_q) < MAX_ENTRIES)) begin
			key_mem[IW'(idx_q)] <= key_q;
			ang_mem[IW'(idx_q)] <= ang_q;
		end
		if (searching_q && (cnt_q < n_use)) begin
			key_rd_s1 <= key_mem[cnt_q[IW-1:0]];
			ang_rd_s1 <= ang_mem[cnt_q[IW-1:0]];
		end
	end

	// clamp and divide by 60
	always_comb begin
		if (rate_q > bti_pkg::RATE_LIMIT) rate_cl = bti_pkg::RATE_LIMIT;
		else if (rate_q < -bti_pkg::RATE_LIMIT) rate_cl = -bti_pkg::RATE_LIMIT;
		else rate_cl = rate_q;
		rate_abs   = rate_cl[bti_pkg::RATE_W-1] ? -rate_cl : rate_cl;
		scale_prod = rmag_q * bti_pkg::RECIP_60;
		vmag       = scale_prod[bti_pkg::RECIP_SHIFT +: bti_pkg::VMAG_W];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_rate_q <= '0;
		end else if (cmd.check) begin
			last_rate_q <= rate_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			rmag_q <= rate_abs[bti_pkg::RMAG_W-1:0];
			rneg_q <= rate_cl[bti_pkg::RATE_W-1];
		end
		if (cmd.scale) begin
			v_q <= rneg_q ? -$signed({1'b0, vmag}) : $signed({1'b0, vmag});
		end
	end

	// streamed search for the first key above v
	always_comb begin
		lt       = $signed({{(bti_pkg::KEY_W - bti_pkg::V_W){v_q[bti_pkg::V_W-1]}}, v_q})
			< key_rd_s1;
		done_now = searching_q && vld_s1 && (lt || (tag_s1 == n_use - CW'(1)));
		sat_now  = lt ? (tag_s1 == '0) : 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			searching_q <= 1'b0;
			vld_s1      <= 1'b0;
		end else if (cmd.search_go) begin
			searching_q <= 1'b1;
			vld_s1      <= 1'b0;
		end else if (searching_q) begin
			if (done_now) begin
				searching_q <= 1'b0;
				vld_s1      <= 1'b0;
			end else begin
				vld_s1 <= (cnt_q < n_use);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.search_go) begin
			cnt_q <= '0;
		end else if (searching_q && !done_now) begin
			tag_s1 <= cnt_q;
			if (cnt_q < n_use) cnt_q <= cnt_q + CW'(1);
		end
		if (searching_q && vld_s1) begin
			if (!lt || tag_s1 == '0) begin
				k0_q <= key_rd_s1;
				a0_q <= ang_rd_s1;
			end else begin
				k1_q <= key_rd_s1;
				a1_q <= ang_rd_s1;
			end
			if (done_now) sat_q <= sat_now;
		end
	end

	// interpolation operands and product
	always_comb begin
		dv = $signed({{5{v_q[bti_pkg::V_W-1]}}, v_q}) - $signed({k0_q[15], k0_q});
		da = $signed({a1_q[15], a1_q}) - $signed({a0_q[15], a0_q});
		dk = $signed({k1_q[15], k1_q}) - $signed({k0_q[15], k0_q});
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			dv_q     <= dv[15:0];
			da_neg_q <= da[16];
			da_mag_q <= da[16] ? 16'(-da) : da[15:0];
			dk_q     <= dk[15:0];
		end
		if (cmd.mul) begin
			prod_q <= dv_q * da_mag_q;
		end
	end

	// radix-4 restoring divide, quotient below 2^16
	always_comb begin
		r1  = {rem_q[15:0], dl_q[15]};
		qb1 = (r1 >= {1'b0, dk_q});
		r1b = qb1 ? r1 - {1'b0, dk_q} : r1;
		r2  = {r1b[15:0], dl_q[14]};
		qb2 = (r2 >= {1'b0, dk_q});
		r2b = qb2 ? r2 - {1'b0, dk_q} : r2;
	end

	always_ff @(posedge clk) begin
		if (cmd.div_load) begin
			rem_q  <= {1'b0, prod_q[31:16]};
			dl_q   <= prod_q[15:0];
			quo_q  <= '0;
			dcnt_q <= '0;
		end else if (cmd.div_step) begin
			rem_q  <= r2b;
			dl_q   <= {dl_q[13:0], 2'b00};
			quo_q  <= {quo_q[13:0], qb1, qb2};
			dcnt_q <= dcnt_q + bti_pkg::DIV_CNT_W'(1);
		end
	end

	// result register
	always_comb begin
		sq      = da_neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q});
		base    = sat_q ? $signed({{2{a0_q[15]}}, a0_q})
			: $signed({{2{a0_q[15]}}, a0_q}) + sq;
		neg_res = -base;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) res_q <= neg_res[bti_pkg::OUT_W-1:0];
	end

	always_comb begin
		sts.mode        = mode_q;
		sts.rate_same   = (rate_q == last_rate_q);
		sts.search_done = done_now;
		sts.search_sat  = sat_now;
		sts.div_last    = (dcnt_q == bti_pkg::DIV_LAST);
		sts.out_free    = !m_tvalid_q || m_tready;
		m_tvalid        = m_tvalid_q;
		res_data        = res_q;
	end

endmodule

`default_nettype wire

// ===== hdl/breakpoint_table_interpolator_top.sv =====
// top level of the breakpoint table interpolator
//
// Input stream s_*: tuser is the mode. Mode 0 writes one breakpoint
// (index, key, angle) into the table and gives no result. Mode 1 carries
// a climb rate; a rate equal to the previous converted one gives nothing,
// any other gives one item on m_* holding the negated needle angle.
// cfg_wen/cfg_wdata write the number of breakpoints in use (saturated
// to 2..MAX_ENTRIES); write it only while the block is idle.
// One item at a time: a write item or a repeated rate ends after the decode
// state. A conversion of a rate outside the table goes from the search
// straight to the output; one that interpolates passes through the operand,
// multiply and divide states. The table is read one entry a cycle from a
// single memory port, and the quotient comes from a radix-4 divider.
// The result sits in an output register, so the next item is taken while
// it waits; a conversion finishing while the register is still full holds
// until m_tready frees it. Reset empties the output, sets the entry count
// to 2 and the previous rate to zero; table contents stay undefined.
`default_nettype none

module breakpoint_table_interpolator_top #(
	parameter int MAX_ENTRIES = 16
) (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_tvalid,
	output logic                             s_tready,
	// entry_index, entry_key, entry_angle, climb_rate, zero pad
	input  wire  [bti_pkg::S_DATA_W-1:0]     s_tdata,
	// mode
	input  wire                              s_tuser,
	output logic                             m_tvalid,
	input  wire                              m_tready,
	// needle_angle, zero pad
	output logic [bti_pkg::M_DATA_W-1:0]     m_tdata,
	input  wire                              cfg_wen,
	input  wire  [bti_pkg::ENTRY_W-1:0]      cfg_wdata
);

	bti_pkg::bti_cmd_t            cmd;
	bti_pkg::bti_sts_t            sts;
	logic [bti_pkg::OUT_W-1:0]    res_data;

	bti_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	bti_dpath #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.res_data  (res_data)
	);

	assign m_tdata = {{(bti_pkg::M_DATA_W - bti_pkg::OUT_W){1'b0}}, res_data};

endmodule

`default_nettype wire
